@@ rtl/btop_pkg.sv @@
// shared types, register indexes and fixed-point helpers for the binomial tree pricer
// no dependencies; imported by binomial_tree_option_pricer
`default_nettype none

package btop_pkg;

   // one price, factor or weight word
   typedef logic [31:0] word_type;

   // csr register indexes (byte address bits [3:2])
   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_SPOT_PRICE  = 2'd0;
   localparam csr_index_type CSR_STRIKE      = 2'd1;
   localparam csr_index_type CSR_IS_CALL     = 2'd2;
   localparam csr_index_type CSR_IS_EUROPEAN = 2'd3;

   localparam int unsigned FRAC_BITS = 30;

   // clipped value with its overflow flag
   typedef struct packed {
      logic     sat;
      word_type value;
   } clip_type;

   // 64-bit product shifted down by the fraction bits, clipped to 32 bits
   function automatic clip_type clip_product(input logic [63:0] prod);
      clip_type r;
      r.sat   = |prod[63:62];
      r.value = r.sat ? '1 : prod[61:30];
      return r;
   endfunction

   // 65-bit sum of two products, shifted and clipped the same way
   function automatic clip_type clip_sum(input logic [64:0] sum);
      clip_type r;
      r.sat   = |sum[64:62];
      r.value = r.sat ? '1 : sum[61:30];
      return r;
   endfunction

   // intrinsic value floored at zero
   function automatic word_type payoff(input word_type x, input word_type strike,
                                       input logic call);
      word_type r;
      if (call) begin
         r = (x > strike) ? x - strike : '0;
      end else begin
         r = (strike > x) ? strike - x : '0;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ rtl/binomial_tree_option_pricer.sv @@
// binomial tree option pricer top level: csr block, sequencer, shared multiplier
// depends on btop_pkg and btop_ram
`default_nettype none

//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------------------
//  req     | in        | req_valid / req_stall  | steps, up/down factor, down/up weight
//  rsp     | out       | rsp_valid / rsp_stall  | option_value, saturated
//  csr     | in/out    | psel/penable/pready    | spot, strike, is_call, is_european
//
//  one word at a time; the sequencer walks every tree node through one shared
//  32x32 multiplier and one node memory (one read, one write per cycle).
//  a european or call rollback node reads a child, weights both children and sums them;
//  american put nodes add up moves and an exercise compare; level bases are re-derived.
//  reset is synchronous; no memory clearing pass, every leaf is written before it is read.
//  a finished word waits in the rsp register; a new req word is taken meanwhile.

module binomial_tree_option_pricer #(
   parameter int unsigned MAX_STEPS = 1024
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // request channel
   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire logic [10:0]       req_steps,
   input  wire btop_pkg::word_type req_up_factor,
   input  wire btop_pkg::word_type req_down_factor,
   input  wire btop_pkg::word_type req_down_weight,
   input  wire btop_pkg::word_type req_up_weight,
   // response channel
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      btop_pkg::word_type rsp_option_value,
   output      logic              rsp_saturated,
   // csr port
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [3:0]        paddr,
   input  wire btop_pkg::word_type pwdata,
   output      btop_pkg::word_type prdata,
   output      logic              pready
);

   import btop_pkg::*;

   localparam int unsigned DEPTH = MAX_STEPS + 1;
   localparam int unsigned AW    = $clog2(DEPTH);
   localparam logic [AW-1:0] MAX_N = AW'(MAX_STEPS);

   // sequencer states
   localparam logic [4:0] ST_IDLE    = 5'd0;
   localparam logic [4:0] ST_LS_MUL  = 5'd1;   // base price: multiply by down factor
   localparam logic [4:0] ST_LS_ACC  = 5'd2;
   localparam logic [4:0] ST_LEAF_WR = 5'd3;   // write one leaf payoff
   localparam logic [4:0] ST_UP_M1   = 5'd4;   // step underlying up twice
   localparam logic [4:0] ST_UP_M2   = 5'd5;
   localparam logic [4:0] ST_UP_M3   = 5'd6;
   localparam logic [4:0] ST_RB_LVL  = 5'd7;   // start of a rollback level
   localparam logic [4:0] ST_RB_RD0  = 5'd8;
   localparam logic [4:0] ST_RB_LO   = 5'd9;
   localparam logic [4:0] ST_RB_RDH  = 5'd10;
   localparam logic [4:0] ST_RB_M1   = 5'd11;
   localparam logic [4:0] ST_RB_M2   = 5'd12;
   localparam logic [4:0] ST_RB_SUM  = 5'd13;
   localparam logic [4:0] ST_RB_EX   = 5'd14;  // early exercise compare
   localparam logic [4:0] ST_FIN_RD  = 5'd15;
   localparam logic [4:0] ST_FIN_OUT = 5'd16;

   // csr registers
   word_type spot_ff, spot_in;
   word_type strike_ff, strike_in;
   logic     is_call_ff, is_call_in;
   logic     is_european_ff, is_european_in;

   // sequencer and datapath registers
   logic [4:0]    state_ff, state_in;
   logic [AW-1:0] n_ff, n_in;          // tree depth of the current word
   logic [AW-1:0] lvl_ff, lvl_in;      // rollback level being formed
   logic [AW-1:0] j_ff, j_in;          // node index
   logic [AW-1:0] k_ff, k_in;          // down-factor multiply count
   logic          in_roll_ff, in_roll_in;
   logic          early_ff, early_in;
   logic          sat_ff, sat_in;
   word_type      up_ff, up_in;
   word_type      down_ff, down_in;
   word_type      wd_ff, wd_in;
   word_type      wu_ff, wu_in;
   word_type      x_ff, x_in;          // underlying at current node
   word_type      lo_ff, lo_in;        // lower child value
   word_type      hi_ff, hi_in;        // upper child value
   word_type      v_ff, v_in;          // rolled-back value before exercise check
   logic [63:0]   part_ff, part_in;    // lower child weighted product
   logic [63:0]   prod_ff, prod_in;    // shared multiplier output

   // response register
   logic     rsp_valid_ff, rsp_valid_in;
   word_type rsp_value_ff, rsp_value_in;
   logic     rsp_sat_ff, rsp_sat_in;

   // combinational
   word_type      mul_a, mul_b;
   clip_type      prod_clip, sum_clip;
   word_type      ex_value;
   logic [AW-1:0] ls_target;
   logic          csr_write, req_take, out_free;
   logic          ram_wr_en, ram_rd_en;
   logic [AW-1:0] ram_wr_addr, ram_rd_addr;
   word_type      ram_wr_data, ram_rd_data;

   btop_ram #(
      .WIDTH (32),
      .DEPTH (DEPTH)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // csr access
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      case (paddr[3:2])
         CSR_SPOT_PRICE:  prdata = spot_ff;
         CSR_STRIKE:      prdata = strike_ff;
         CSR_IS_CALL:     prdata = {31'd0, is_call_ff};
         CSR_IS_EUROPEAN: prdata = {31'd0, is_european_ff};
         default:         prdata = '0;
      endcase
   end

   always_comb begin
      spot_in        = spot_ff;
      strike_in      = strike_ff;
      is_call_in     = is_call_ff;
      is_european_in = is_european_ff;
      if (csr_write) begin
         case (paddr[3:2])
            CSR_SPOT_PRICE:  spot_in        = pwdata;
            CSR_STRIKE:      strike_in      = pwdata;
            CSR_IS_CALL:     is_call_in     = pwdata[0];
            CSR_IS_EUROPEAN: is_european_in = pwdata[0];
            default:         spot_in        = spot_ff;
         endcase
      end
   end

   // handshakes
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_option_value = rsp_value_ff;
   assign rsp_saturated    = rsp_sat_ff;

   // shared arithmetic
   assign prod_in   = 64'(mul_a) * 64'(mul_b);
   assign prod_clip = clip_product(prod_ff);
   assign sum_clip  = clip_sum({1'b0, part_ff} + {1'b0, prod_ff});
   assign ex_value  = payoff(x_ff, strike_ff, is_call_ff);
   assign ls_target = in_roll_ff ? lvl_ff : n_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      lvl_in       = lvl_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      in_roll_in   = in_roll_ff;
      early_in     = early_ff;
      sat_in       = sat_ff;
      up_in        = up_ff;
      down_in      = down_ff;
      wd_in        = wd_ff;
      wu_in        = wu_ff;
      x_in         = x_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      v_in         = v_ff;
      part_in      = part_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_sat_in   = rsp_sat_ff;
      mul_a        = x_ff;
      mul_b        = down_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = j_ff;
      ram_wr_data  = ex_value;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = j_ff + AW'(1);

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               // steps beyond the memory depth are clipped
               n_in       = (32'(req_steps) > 32'(MAX_STEPS)) ? MAX_N : AW'(req_steps);
               up_in      = req_up_factor;
               down_in    = req_down_factor;
               wd_in      = req_down_weight;
               wu_in      = req_up_weight;
               early_in   = !is_call_ff && !is_european_ff;
               sat_in     = 1'b0;
               x_in       = spot_ff;
               k_in       = '0;
               j_in       = '0;
               in_roll_in = 1'b0;
               state_in   = ST_LS_MUL;
            end
         end

         // base price of a level: spot times down factor, level times
         ST_LS_MUL: begin
            mul_a = x_ff;
            mul_b = down_ff;
            if (k_ff == ls_target) begin
               j_in     = '0;
               state_in = in_roll_ff ? ST_RB_RD0 : ST_LEAF_WR;
            end else begin
               state_in = ST_LS_ACC;
            end
         end

         ST_LS_ACC: begin
            x_in     = prod_clip.value;
            sat_in   = sat_ff | prod_clip.sat;
            k_in     = k_ff + AW'(1);
            state_in = ST_LS_MUL;
         end

         ST_LEAF_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = ex_value;
            if (j_ff == n_ff) begin
               in_roll_in = 1'b1;
               if (n_ff == '0) begin
                  state_in = ST_FIN_RD;
               end else begin
                  lvl_in   = n_ff - AW'(1);
                  state_in = ST_RB_LVL;
               end
            end else begin
               j_in     = j_ff + AW'(1);
               state_in = ST_UP_M1;
            end
         end

         // two up moves per node step, each truncated and clipped
         ST_UP_M1: begin
            mul_a    = x_ff;
            mul_b    = up_ff;
            state_in = ST_UP_M2;
         end

         ST_UP_M2: begin
            mul_a    = prod_clip.value;
            mul_b    = up_ff;
            sat_in   = sat_ff | prod_clip.sat;
            state_in = ST_UP_M3;
         end

         ST_UP_M3: begin
            x_in     = prod_clip.value;
            sat_in   = sat_ff | prod_clip.sat;
            state_in = in_roll_ff ? ST_RB_EX : ST_LEAF_WR;
         end

         ST_RB_LVL: begin
            if (early_ff) begin
               x_in     = spot_ff;
               k_in     = '0;
               state_in = ST_LS_MUL;
            end else begin
               state_in = ST_RB_RD0;
            end
         end

         ST_RB_RD0: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = '0;
            j_in        = '0;
            state_in    = ST_RB_LO;
         end

         ST_RB_LO: begin
            lo_in    = ram_rd_data;
            state_in = ST_RB_RDH;
         end

         ST_RB_RDH: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = j_ff + AW'(1);
            state_in    = ST_RB_M1;
         end

         ST_RB_M1: begin
            hi_in    = ram_rd_data;
            mul_a    = lo_ff;
            mul_b    = wd_ff;
            state_in = ST_RB_M2;
         end

         ST_RB_M2: begin
            part_in  = prod_ff;
            mul_a    = hi_ff;
            mul_b    = wu_ff;
            state_in = ST_RB_SUM;
         end

         ST_RB_SUM: begin
            sat_in = sat_ff | sum_clip.sat;
            if (early_ff) begin
               v_in     = sum_clip.value;
               state_in = (j_ff == '0) ? ST_RB_EX : ST_UP_M1;
            end else begin
               ram_wr_en   = 1'b1;
               ram_wr_data = sum_clip.value;
               lo_in       = hi_ff;
               if (j_ff == lvl_ff) begin
                  if (lvl_ff == '0) begin
                     state_in = ST_FIN_RD;
                  end else begin
                     lvl_in   = lvl_ff - AW'(1);
                     state_in = ST_RB_LVL;
                  end
               end else begin
                  j_in     = j_ff + AW'(1);
                  state_in = ST_RB_RDH;
               end
            end
         end

         // american put: node raised to its exercise value
         ST_RB_EX: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = (v_ff < ex_value) ? ex_value : v_ff;
            lo_in       = hi_ff;
            if (j_ff == lvl_ff) begin
               if (lvl_ff == '0) begin
                  state_in = ST_FIN_RD;
               end else begin
                  lvl_in   = lvl_ff - AW'(1);
                  state_in = ST_RB_LVL;
               end
            end else begin
               j_in     = j_ff + AW'(1);
               state_in = ST_RB_RDH;
            end
         end

         ST_FIN_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = '0;
            state_in    = ST_FIN_OUT;
         end

         // root word held in the ram read register until the rsp slot frees
         ST_FIN_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = ram_rd_data;
               rsp_sat_in   = sat_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spot_ff        <= '0;
         strike_ff      <= '0;
         is_call_ff     <= 1'b1;
         is_european_ff <= 1'b1;
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
      end else begin
         spot_ff        <= spot_in;
         strike_ff      <= strike_in;
         is_call_ff     <= is_call_in;
         is_european_ff <= is_european_in;
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      lvl_ff       <= lvl_in;
      j_ff         <= j_in;
      k_ff         <= k_in;
      in_roll_ff   <= in_roll_in;
      early_ff     <= early_in;
      sat_ff       <= sat_in;
      up_ff        <= up_in;
      down_ff      <= down_in;
      wd_ff        <= wd_in;
      wu_ff        <= wu_in;
      x_ff         <= x_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      v_ff         <= v_in;
      part_ff      <= part_in;
      prod_ff      <= prod_in;
      rsp_value_ff <= rsp_value_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

endmodule

`default_nettype wire

@@ rtl/btop_ram.sv @@
// generic simple dual-port ram: one write port, one read port with registered read data
// no dependencies
`default_nettype none

module btop_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1025
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] storage_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         storage_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= storage_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ test/binomial_tree_option_pricer_tb.sv @@
// self-checking bench for binomial_tree_option_pricer: directed and random tree jobs
// under several market settings, each root price checked against an in-bench lattice model
// depends on btop_pkg and the pricer rtl

module binomial_tree_option_pricer_tb;

   typedef btop_pkg::word_type word_type;

   localparam int TREE_STEPS_MAX = 1024;
   // slowest job sent is a 1024-step european tree, priced with nothing moving on the ports
   localparam int IDLE_LIMIT = 10_000_000;
   localparam int SETTLE_CYCLES = 64;
   localparam word_type Q30_ONE = 32'h4000_0000;
   localparam word_type PRICE_100 = 32'd100 << 16;

   // one tree job as it travels on the req channel
   typedef struct {
      logic [10:0] steps;
      word_type    up_factor;
      word_type    down_factor;
      word_type    down_weight;
      word_type    up_weight;
   } tree_job_type;

   // one root price as it comes back on the rsp channel
   typedef struct {
      word_type option_value;
      logic     saturated;
   } root_price_type;

   logic        clock;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [10:0] req_steps = '0;
   word_type    req_up_factor = '0;
   word_type    req_down_factor = '0;
   word_type    req_down_weight = '0;
   word_type    req_up_weight = '0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   word_type    rsp_option_value;
   logic        rsp_saturated;

   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   word_type    pwdata = '0;
   word_type    prdata;
   logic        pready;

   // market settings as the block should hold them
   word_type    mkt_spot = '0;
   word_type    mkt_strike = '0;
   logic        mkt_call = 1'b1;
   logic        mkt_european = 1'b1;

   tree_job_type   job_queue[$];
   root_price_type expected_prices[$];
   tree_job_type   job_on_wire;

   word_type    tree_nodes[0:TREE_STEPS_MAX];
   logic        clip_flag;

   int          gap_left = 0;
   int          stall_left = 0;
   bit          quiet = 1'b0;
   int          mismatches = 0;
   int          idle_cycles = 0;

   binomial_tree_option_pricer uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_steps        (req_steps),
      .req_up_factor    (req_up_factor),
      .req_down_factor  (req_down_factor),
      .req_down_weight  (req_down_weight),
      .req_up_weight    (req_up_weight),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_option_value (rsp_option_value),
      .rsp_saturated    (rsp_saturated),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------- lattice model

   // price times q30 factor, truncated, clipped to 32 bits
   function automatic word_type scale_q30(input word_type x, input word_type f);
      logic [63:0] p;
      p = (64'(x) * 64'(f)) >> 30;
      if (p > 64'hFFFF_FFFF) begin
         clip_flag = 1'b1;
         p = 64'hFFFF_FFFF;
      end
      return p[31:0];
   endfunction

   // discounted mix of the two children, exact 65-bit sum before the shift
   function automatic word_type blend_children(input word_type lo, input word_type hi,
                                               input word_type wd, input word_type wu);
      logic [64:0] s;
      s = ((65'(wd) * 65'(lo)) + (65'(wu) * 65'(hi))) >> 30;
      if (s > 65'h0_FFFF_FFFF) begin
         clip_flag = 1'b1;
         s = 65'h0_FFFF_FFFF;
      end
      return s[31:0];
   endfunction

   function automatic word_type exercise_value(input word_type x);
      word_type r;
      if (mkt_call) begin
         r = (x > mkt_strike) ? x - mkt_strike : '0;
      end else begin
         r = (mkt_strike > x) ? mkt_strike - x : '0;
      end
      return r;
   endfunction

   // lowest node of a level: spot walked down once per level
   function automatic word_type level_base(input int lvl, input word_type down);
      word_type x;
      x = mkt_spot;
      for (int k = 0; k < lvl; k++) begin
         x = scale_q30(x, down);
      end
      return x;
   endfunction

   function automatic root_price_type price_tree(input tree_job_type job);
      int             n;
      logic           early;
      word_type       under;
      word_type       v;
      word_type       ex;
      root_price_type r;
      n = job.steps;
      if (n > TREE_STEPS_MAX) begin
         n = TREE_STEPS_MAX;
      end
      // early exercise only for an american put
      early = !mkt_call && !mkt_european;
      clip_flag = 1'b0;
      // leaves, lowest first; each node two up moves above the last
      under = level_base(n, job.down_factor);
      for (int j = 0; j <= n; j++) begin
         if (j > 0) begin
            under = scale_q30(scale_q30(under, job.up_factor), job.up_factor);
         end
         tree_nodes[j] = exercise_value(under);
      end
      // roll back one level at a time, in place
      for (int lvl = n - 1; lvl >= 0; lvl--) begin
         if (early) begin
            under = level_base(lvl, job.down_factor);
         end
         for (int j = 0; j <= lvl; j++) begin
            v = blend_children(tree_nodes[j], tree_nodes[j + 1],
                               job.down_weight, job.up_weight);
            if (early) begin
               if (j > 0) begin
                  under = scale_q30(scale_q30(under, job.up_factor), job.up_factor);
               end
               ex = exercise_value(under);
               if (v < ex) begin
                  v = ex;
               end
            end
            tree_nodes[j] = v;
         end
      end
      r.option_value = tree_nodes[0];
      r.saturated    = clip_flag;
      return r;
   endfunction

   // ---------------------------------------------------------------- request driver

   // a word leaves the queue when it goes on the wire and is priced when taken
   always @(posedge clock) begin : drive_jobs
      logic load_next;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         load_next = !req_valid;
         if (req_valid && !req_stall) begin
            expected_prices.push_back(price_tree(job_on_wire));
            gap_left  = quiet ? 0 : $urandom_range(0, 18);
            load_next = 1'b1;
         end
         if (load_next) begin
            if (gap_left > 0) begin
               gap_left = gap_left - 1;
               req_valid <= 1'b0;
            end else if (job_queue.size() > 0) begin
               job_on_wire = job_queue.pop_front();
               req_steps       <= job_on_wire.steps;
               req_up_factor   <= job_on_wire.up_factor;
               req_down_factor <= job_on_wire.down_factor;
               req_down_weight <= job_on_wire.down_weight;
               req_up_weight   <= job_on_wire.up_weight;
               req_valid       <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- result monitor

   // each result is held off by a stall drawn when the result before it was taken
   always @(posedge clock) begin : check_prices
      root_price_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_prices.size() == 0) begin
               $error("unexpected result: option_value %h saturated %b",
                      rsp_option_value, rsp_saturated);
               mismatches = mismatches + 1;
            end else begin
               want = expected_prices.pop_front();
               if (rsp_option_value !== want.option_value) begin
                  $error("option_value: expected %h, got %h",
                         want.option_value, rsp_option_value);
                  mismatches = mismatches + 1;
               end
               if (rsp_saturated !== want.saturated) begin
                  $error("saturated: expected %b, got %b", want.saturated, rsp_saturated);
                  mismatches = mismatches + 1;
               end
            end
            stall_left = quiet ? 0 : $urandom_range(0, 18);
         end else if (rsp_valid && stall_left > 0) begin
            stall_left = stall_left - 1;
         end
         rsp_stall <= (stall_left > 0);
      end
   end

   // ---------------------------------------------------------------- watchdog

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (psel && penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("binomial_tree_option_pricer test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- stimulus

   // setup cycle, then access cycle; the register takes the value on the access edge
   task automatic write_register(input btop_pkg::csr_index_type idx, input word_type value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         btop_pkg::CSR_SPOT_PRICE:  mkt_spot     = value;
         btop_pkg::CSR_STRIKE:      mkt_strike   = value;
         btop_pkg::CSR_IS_CALL:     mkt_call     = value[0];
         btop_pkg::CSR_IS_EUROPEAN: mkt_european = value[0];
         default: ;
      endcase
   endtask

   task automatic set_market(input word_type spot, input word_type strike,
                             input logic call, input logic european);
      write_register(btop_pkg::CSR_SPOT_PRICE, spot);
      write_register(btop_pkg::CSR_STRIKE, strike);
      write_register(btop_pkg::CSR_IS_CALL, {31'b0, call});
      write_register(btop_pkg::CSR_IS_EUROPEAN, {31'b0, european});
      @(negedge clock);
   endtask

   // sender holds off until every word is taken and every price is back
   task automatic wait_drained();
      do @(negedge clock);
      while (job_queue.size() != 0 || req_valid || expected_prices.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // plausible lattice: up 1.0 .. 1.0 + up_span, down its reciprocal, weights summing to 1 or just under
   function automatic tree_job_type market_job(input int n, input word_type up_span);
      tree_job_type    t;
      longint unsigned total;
      t.steps       = 11'(n);
      t.up_factor   = Q30_ONE + $urandom_range(0, up_span);
      t.down_factor = 32'(64'h1000_0000_0000_0000 / t.up_factor);
      total         = Q30_ONE - $urandom_range(0, 32'h0040_0000);
      t.up_weight   = 32'(total * $urandom_range(35, 65) / 100);
      t.down_weight = 32'(total - t.up_weight);
      return t;
   endfunction

   function automatic tree_job_type flat_job(input int n, input word_type f);
      tree_job_type t;
      t.steps       = 11'(n);
      t.up_factor   = f;
      t.down_factor = f;
      t.down_weight = f;
      t.up_weight   = f;
      return t;
   endfunction

   function automatic tree_job_type noise_job(input int n);
      tree_job_type t;
      t.steps       = 11'(n);
      t.up_factor   = $urandom;
      t.down_factor = $urandom;
      t.down_weight = $urandom;
      t.up_weight   = $urandom;
      return t;
   endfunction

   // well-formed job with one field knocked out of shape
   function automatic tree_job_type broken_job(input int n);
      tree_job_type t;
      word_type     junk;
      t = market_job(n, 32'h0800_0000);
      case ($urandom_range(0, 2))
         0: junk = '0;
         1: junk = '1;
         default: junk = $urandom;
      endcase
      case ($urandom_range(0, 3))
         0: t.up_factor = junk;
         1: t.down_factor = junk;
         2: t.down_weight = junk;
         default: t.up_weight = junk;
      endcase
      return t;
   endfunction

   // mostly shallow trees so american puts stay cheap
   function automatic int pick_steps();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) begin
         return $urandom_range(0, 16);
      end else if (r < 97) begin
         return $urandom_range(17, 40);
      end
      return $urandom_range(41, 96);
   endfunction

   function automatic word_type pick_price();
      if ($urandom_range(0, 9) == 0) begin
         return $urandom;
      end
      return $urandom_range(32'd50 << 16, 32'd150 << 16);
   endfunction

   initial begin : stimulus
      int r;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // european call at the money: zero-step root, tiny trees, degenerate factors,
      // and the two deepest trees (exactly max and clipped down to max)
      set_market(PRICE_100, PRICE_100, 1'b1, 1'b1);
      job_queue.push_back(market_job(0, 32'h0800_0000));
      job_queue.push_back(market_job(1, 32'h0800_0000));
      job_queue.push_back(market_job(2, 32'h0800_0000));
      job_queue.push_back(flat_job(3, '0));
      job_queue.push_back(flat_job(3, '1));
      job_queue.push_back(flat_job(5, Q30_ONE));
      job_queue.push_back(market_job(1024, 32'h0001_0000));
      job_queue.push_back(market_job(2047, 32'h0001_0000));
      wait_drained();

      // european put with spot at zero and the largest strike
      quiet = 1'b1;
      set_market('0, '1, 1'b0, 1'b1);
      job_queue.push_back(market_job(0, 32'h0800_0000));
      job_queue.push_back(market_job(4, 32'h0800_0000));
      job_queue.push_back(flat_job(2, '1));
      wait_drained();

      // american put, in the money: exercise value checked at every node
      quiet = 1'b0;
      set_market(PRICE_100, 32'd110 << 16, 1'b0, 1'b0);
      job_queue.push_back(market_job(0, 32'h0800_0000));
      job_queue.push_back(market_job(1, 32'h0800_0000));
      job_queue.push_back(market_job(6, 32'h0800_0000));
      job_queue.push_back(market_job(12, 32'h0800_0000));
      job_queue.push_back(flat_job(3, '1));
      job_queue.push_back(flat_job(3, '0));
      wait_drained();

      // american call goes through as european
      set_market(PRICE_100, 32'd90 << 16, 1'b1, 1'b0);
      job_queue.push_back(market_job(5, 32'h0800_0000));
      job_queue.push_back(market_job(10, 32'h0800_0000));
      wait_drained();

      // largest spot, zero strike
      set_market('1, '0, 1'b1, 1'b1);
      job_queue.push_back(market_job(3, 32'h0800_0000));
      job_queue.push_back(flat_job(2, '0));
      wait_drained();

      // random markets, each phase drained before the next setting
      for (int phase = 0; phase < 6; phase++) begin
         quiet = ($urandom_range(0, 3) == 0);
         set_market(pick_price(), pick_price(), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
         for (int k = 0; k < 14; k++) begin
            r = $urandom_range(0, 99);
            if (r < 75) begin
               job_queue.push_back(market_job(pick_steps(), 32'h0800_0000));
            end else if (r < 88) begin
               job_queue.push_back(broken_job(pick_steps()));
            end else begin
               job_queue.push_back(noise_job(pick_steps()));
            end
         end
         wait_drained();
      end

      if (mismatches == 0 && expected_prices.size() == 0) begin
         $display("binomial_tree_option_pricer test passed");
      end else begin
         $display("binomial_tree_option_pricer test failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/btop_pkg.sv
rtl/btop_ram.sv
rtl/binomial_tree_option_pricer.sv
test/binomial_tree_option_pricer_tb.sv
